// ----- sv/twcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package twcs_pkg;

	// Fixed-point and field geometry. Texture sizes are powers of two so that
	// texture coordinates wrap by masking.
	localparam int FRAC_BITS  = 16;
	localparam int TEX_W_BITS = 6;
	localparam int TEX_H_BITS = 6;
	localparam int ROW_W      = 12;
	localparam int DIST_W     = 32;
	localparam int DIR_W      = 19;
	localparam int LINE_W     = ROW_W + FRAC_BITS;
	localparam int POS_W      = TEX_H_BITS + FRAC_BITS;
	localparam int STEP_W     = 23;
	localparam int PROD_W     = 2 * FRAC_BITS;

	localparam logic [STEP_W-1:0] STEP_LIMIT          = {STEP_W{1'b1}};
	localparam logic [ROW_W-1:0]  SCREEN_HEIGHT_RESET = ROW_W'(480);

	localparam logic OP_SETUP = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	typedef enum logic [1:0] {
		FACE_NORTH = 2'd0,
		FACE_SOUTH = 2'd1,
		FACE_WEST  = 2'd2,
		FACE_EAST  = 2'd3
	} face_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LINE_GO,
		ST_LINE_WAIT,
		ST_STEP_GO,
		ST_STEP_WAIT,
		ST_POS,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic pixel;
		logic div_start;
		logic div_sel_step;
		logic line_load;
		logic geom_load;
		logic step_load;
		logic pos_load;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic queue_full;
	} status_t;

	typedef struct packed {
		logic [ROW_W-1:0]      draw_start;
		logic [ROW_W-1:0]      draw_end;
		logic [ROW_W-1:0]      screen_row;
		logic [TEX_W_BITS-1:0] texel_x;
		logic [TEX_H_BITS-1:0] texel_y;
		face_t                 wall_face;
		logic                  shade;
		logic                  pixel_valid;
		logic                  last;
	} result_t;

endpackage

`default_nettype wire

// ----- sv/twcs_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. A zero divisor gives an
// all-ones quotient.
module twcs_divider #(
	parameter int DVD_W = 28,
	parameter int DVS_W = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic [DVD_W-1:0]      quotient
);
	localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DVD_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;
	logic [DVS_W-1:0] rem_next;

	assign trial    = {rem_q, quo_q[DVD_W-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign diff     = trial - {1'b0, dvs_q};
	assign rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= LAST_CNT;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- sv/twcs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module twcs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              operation,
	input  wire twcs_pkg::status_t status,
	output logic                   in_stall,
	output twcs_pkg::cmd_t         cmd
);
	import twcs_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !status.queue_full && operation == OP_SETUP) begin
					state_d = ST_LINE_GO;
				end
			end
			ST_LINE_GO:   state_d = ST_LINE_WAIT;
			ST_LINE_WAIT: begin
				if (status.div_done) begin
					state_d = ST_STEP_GO;
				end
			end
			ST_STEP_GO:   state_d = ST_STEP_WAIT;
			ST_STEP_WAIT: begin
				if (status.div_done) begin
					state_d = ST_POS;
				end
			end
			ST_POS:       state_d = ST_COMMIT;
			ST_COMMIT: begin
				if (!status.queue_full) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = status.queue_full;
				if (in_valid && !status.queue_full) begin
					cmd.capture = (operation == OP_SETUP);
					cmd.pixel   = (operation == OP_PIXEL);
				end
			end
			ST_LINE_GO: begin
				cmd.div_start = 1'b1;
			end
			ST_LINE_WAIT: begin
				cmd.line_load = status.div_done;
			end
			ST_STEP_GO: begin
				cmd.div_start    = 1'b1;
				cmd.div_sel_step = 1'b1;
				cmd.geom_load    = 1'b1;
			end
			ST_STEP_WAIT: begin
				cmd.step_load = status.div_done;
			end
			ST_POS: begin
				cmd.pos_load = 1'b1;
			end
			ST_COMMIT: begin
				cmd.commit = !status.queue_full;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/twcs_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module twcs_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire twcs_pkg::cmd_t                cmd,
	output twcs_pkg::status_t                  status,
	input  wire logic                          cfg_write_en,
	input  wire logic [twcs_pkg::ROW_W-1:0]    cfg_write_data,
	input  wire logic [twcs_pkg::DIST_W-1:0]   perp_distance,
	input  wire logic                          hit_side,
	input  wire logic signed [twcs_pkg::DIR_W-1:0] ray_dir_x,
	input  wire logic signed [twcs_pkg::DIR_W-1:0] ray_dir_y,
	input  wire logic [twcs_pkg::DIST_W-1:0]   player_x,
	input  wire logic [twcs_pkg::DIST_W-1:0]   player_y,
	input  wire logic                          step_x_negative,
	input  wire logic                          step_y_negative,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output twcs_pkg::result_t                  result
);
	import twcs_pkg::*;

	localparam logic [LINE_W-1:0] STEP_DIVIDEND = LINE_W'(1) << POS_W;

	// Configuration and column state.
	logic [ROW_W-1:0]      screen_height_q;
	logic [ROW_W-1:0]      current_row_q;
	logic [ROW_W-1:0]      end_row_q;
	logic [ROW_W-1:0]      col_start_q;
	logic [POS_W-1:0]      tex_pos_q;
	logic [STEP_W-1:0]     tex_step_q;
	logic [TEX_W_BITS-1:0] col_texel_q;
	face_t                 col_face_q;
	logic                  col_shade_q;

	// Setup working registers.
	logic [DIST_W-1:0]       pd_q;
	logic                    side_q;
	logic [FRAC_BITS-1:0]    base_lo_q;
	logic signed [DIR_W-1:0] dir_q;
	logic                    flip_q;
	face_t                   face_q;
	logic [FRAC_BITS-1:0]    prod_hi_q;
	logic [LINE_W-1:0]       line_q;
	logic [ROW_W-1:0]        start_q;
	logic [ROW_W-1:0]        end_q;
	logic [POS_W-1:0]        offset_q;
	logic [STEP_W-1:0]       step_q;
	logic [POS_W-1:0]        pos_q;

	// Output queue, two entries.
	result_t    q0_q;
	result_t    q1_q;
	logic [1:0] count_q;

	logic [PROD_W-1:0]     dir_ext;
	logic [PROD_W-1:0]     prod;
	logic [LINE_W-1:0]     div_dividend;
	logic [DIST_W-1:0]     div_divisor;
	logic                  div_done;
	logic [LINE_W-1:0]     div_quotient;
	logic [LINE_W-2:0]     half_l;
	logic [LINE_W-2:0]     half_h;
	logic [LINE_W-2:0]     offset_diff;
	logic [LINE_W-1:0]     end_sum;
	logic [FRAC_BITS-1:0]  frac;
	logic [TEX_W_BITS-1:0] tex_col;
	logic [TEX_W_BITS-1:0] texel_new;
	logic                  active;
	logic                  last_row;
	logic                  push;
	logic                  pop;
	result_t               setup_res;
	result_t               pixel_res;
	result_t               push_res;

	// Wall hit fraction: only bits [2F-1:F] of distance times direction matter,
	// so a truncated product of PROD_W bits is enough.
	assign dir_ext = {{(PROD_W - DIR_W){dir_q[DIR_W-1]}}, dir_q};
	assign prod    = PROD_W'(pd_q) * dir_ext;

	assign div_dividend = cmd.div_sel_step ? STEP_DIVIDEND
	                                       : {screen_height_q, {FRAC_BITS{1'b0}}};
	assign div_divisor  = cmd.div_sel_step ? DIST_W'(line_q) : pd_q;

	twcs_divider #(
		.DVD_W(LINE_W),
		.DVS_W(DIST_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign half_l      = line_q[LINE_W-1:1];
	assign half_h      = (LINE_W-1)'(screen_height_q[ROW_W-1:1]);
	assign offset_diff = half_l - half_h;
	assign end_sum     = LINE_W'(half_l) + LINE_W'(half_h);

	assign frac      = base_lo_q + prod_hi_q;
	assign tex_col   = frac[FRAC_BITS-1:FRAC_BITS-TEX_W_BITS];
	assign texel_new = flip_q ? ~tex_col : tex_col;

	assign active   = current_row_q < end_row_q;
	assign last_row = ((ROW_W+1)'(current_row_q) + (ROW_W+1)'(1)) == (ROW_W+1)'(end_row_q);

	always_ff @(posedge clk) begin
		prod_hi_q <= prod[PROD_W-1:FRAC_BITS];
		if (cmd.capture) begin
			pd_q      <= (perp_distance == '0) ? DIST_W'(1) : perp_distance;
			side_q    <= hit_side;
			base_lo_q <= hit_side ? player_x[FRAC_BITS-1:0] : player_y[FRAC_BITS-1:0];
			dir_q     <= hit_side ? ray_dir_x : ray_dir_y;
			flip_q    <= hit_side ? ray_dir_y[DIR_W-1]
			                      : (!ray_dir_x[DIR_W-1] && ray_dir_x != '0);
			face_q    <= hit_side ? (step_y_negative ? FACE_SOUTH : FACE_NORTH)
			                      : (step_x_negative ? FACE_EAST : FACE_WEST);
		end
		if (cmd.line_load) begin
			line_q <= div_quotient;
		end
		if (cmd.geom_load) begin
			start_q  <= (half_l >= half_h) ? '0
			            : ROW_W'(half_h) - ROW_W'(half_l);
			end_q    <= (end_sum >= LINE_W'(screen_height_q)) ? screen_height_q
			            : end_sum[ROW_W-1:0];
			offset_q <= (half_l > half_h) ? offset_diff[POS_W-1:0] : '0;
		end
		if (cmd.step_load) begin
			step_q <= (div_quotient > LINE_W'(STEP_LIMIT)) ? STEP_LIMIT
			          : div_quotient[STEP_W-1:0];
		end
		if (cmd.pos_load) begin
			pos_q <= offset_q * step_q[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_height_q <= SCREEN_HEIGHT_RESET;
			current_row_q   <= '0;
			end_row_q       <= '0;
			col_start_q     <= '0;
			tex_pos_q       <= '0;
			tex_step_q      <= '0;
			col_texel_q     <= '0;
			col_face_q      <= FACE_NORTH;
			col_shade_q     <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				screen_height_q <= cfg_write_data;
			end
			if (cmd.commit) begin
				current_row_q <= start_q;
				end_row_q     <= end_q;
				col_start_q   <= start_q;
				tex_pos_q     <= pos_q;
				tex_step_q    <= step_q;
				col_texel_q   <= texel_new;
				col_face_q    <= face_q;
				col_shade_q   <= side_q;
			end else if (cmd.pixel && active) begin
				current_row_q <= current_row_q + ROW_W'(1);
				tex_pos_q     <= tex_pos_q + tex_step_q[POS_W-1:0];
			end
		end
	end

	always_comb begin
		setup_res.draw_start  = start_q;
		setup_res.draw_end    = end_q;
		setup_res.screen_row  = start_q;
		setup_res.texel_x     = texel_new;
		setup_res.texel_y     = pos_q[POS_W-1:FRAC_BITS];
		setup_res.wall_face   = face_q;
		setup_res.shade       = side_q;
		setup_res.pixel_valid = 1'b0;
		setup_res.last        = 1'b0;

		pixel_res.draw_start  = col_start_q;
		pixel_res.draw_end    = end_row_q;
		pixel_res.screen_row  = current_row_q;
		pixel_res.texel_x     = col_texel_q;
		pixel_res.texel_y     = tex_pos_q[POS_W-1:FRAC_BITS];
		pixel_res.wall_face   = col_face_q;
		pixel_res.shade       = col_shade_q;
		pixel_res.pixel_valid = active;
		pixel_res.last        = active && last_row;
	end

	assign push     = cmd.pixel || cmd.commit;
	assign push_res = cmd.commit ? setup_res : pixel_res;
	assign pop      = (count_q != 2'd0) && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (count_q == 2'd0) begin
				q0_q <= push_res;
			end else begin
				q1_q <= push_res;
			end
		end else if (pop && !push) begin
			q0_q <= q1_q;
		end else if (push && pop) begin
			if (count_q == 2'd1) begin
				q0_q <= push_res;
			end else begin
				q0_q <= q1_q;
				q1_q <= push_res;
			end
		end
	end

	assign status.div_done   = div_done;
	assign status.queue_full = (count_q == 2'd2);
	assign out_valid         = (count_q != 2'd0);
	assign result            = q0_q;

endmodule

`default_nettype wire

// ----- sv/textured_wall_column_stepper.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Carries
// in        to block   in_valid / in_stall  setup hit or pixel request
// out       from block out_valid/out_stall  column geometry and one pixel
// cfg       to block   cfg_write_en         screen_height write
//
// Pixel items stream at one per cycle while the output queue is not full.
// A setup transfer occupies the block while the shared restoring divider,
// which produces one quotient bit per cycle, runs twice: once for the
// 28-bit line height quotient and once for the 28-bit texture step quotient.
// Reset clears the controller, the output queue and all column state and
// loads a screen height of 480; no clearing pass is needed.
// A two-entry output queue lets new items transfer while a result is stalled.
//
// Each input item produces exactly one result. A setup item computes the
// wall line height from the perpendicular distance, the clamped draw window,
// the mirrored texture column and the wall face, the texture step per row,
// and the texture row at the first visible screen row. Each pixel item then
// walks one row down the column. Downstream shading of Y-side walls halves
// the color and masks it with 0x7F7F7F.
module textured_wall_column_stepper (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write_en,
	input  wire logic [twcs_pkg::ROW_W-1:0]        cfg_write_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              operation,
	input  wire logic [twcs_pkg::DIST_W-1:0]       perp_distance,
	input  wire logic                              hit_side,
	input  wire logic signed [twcs_pkg::DIR_W-1:0] ray_dir_x,
	input  wire logic signed [twcs_pkg::DIR_W-1:0] ray_dir_y,
	input  wire logic [twcs_pkg::DIST_W-1:0]       player_x,
	input  wire logic [twcs_pkg::DIST_W-1:0]       player_y,
	input  wire logic                              step_x_negative,
	input  wire logic                              step_y_negative,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [twcs_pkg::ROW_W-1:0]             draw_start,
	output logic [twcs_pkg::ROW_W-1:0]             draw_end,
	output logic [twcs_pkg::ROW_W-1:0]             screen_row,
	output logic [twcs_pkg::TEX_W_BITS-1:0]        texel_x,
	output logic [twcs_pkg::TEX_H_BITS-1:0]        texel_y,
	output logic [1:0]                             wall_face,
	output logic                                   shade,
	output logic                                   pixel_valid,
	output logic                                   last
);
	import twcs_pkg::*;

	cmd_t    cmd;
	status_t status;
	result_t result;

	// The controller sequences setup through the divider and decides when
	// a transfer is taken; the datapath holds all arithmetic and column state.
	twcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.status    (status),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	twcs_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_write_en    (cfg_write_en),
		.cfg_write_data  (cfg_write_data),
		.perp_distance   (perp_distance),
		.hit_side        (hit_side),
		.ray_dir_x       (ray_dir_x),
		.ray_dir_y       (ray_dir_y),
		.player_x        (player_x),
		.player_y        (player_y),
		.step_x_negative (step_x_negative),
		.step_y_negative (step_y_negative),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.result          (result)
	);

	// The result struct is spread onto the individual output ports.
	assign draw_start  = result.draw_start;
	assign draw_end    = result.draw_end;
	assign screen_row  = result.screen_row;
	assign texel_x     = result.texel_x;
	assign texel_y     = result.texel_y;
	assign wall_face   = result.wall_face;
	assign shade       = result.shade;
	assign pixel_valid = result.pixel_valid;
	assign last        = result.last;

endmodule

`default_nettype wire

// ----- sv/twcs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module twcs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [11:0] draw_start,
	input wire logic [11:0] draw_end,
	input wire logic [11:0] screen_row,
	input wire logic [5:0]  texel_x,
	input wire logic [5:0]  texel_y,
	input wire logic [1:0]  wall_face,
	input wire logic        shade,
	input wire logic        pixel_valid,
	input wire logic        last
);

	// A stalled result keeps its contents until it is transferred.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(screen_row)
		&& $stable(texel_y) && $stable(pixel_valid) && $stable(last))
		else $error("stalled result changed");

	// The last marker only appears on a real pixel.
	a_last_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> pixel_valid)
		else $error("last without pixel");

	// Every pixel row lies inside the column's draw window.
	a_row_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_valid |-> screen_row >= draw_start && screen_row < draw_end)
		else $error("pixel row outside draw window");

	// The clamped window never inverts.
	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> draw_start <= draw_end)
		else $error("draw window inverted");

endmodule

bind textured_wall_column_stepper twcs_checker u_twcs_checker (.*);

`default_nettype wire

// ----- dv/textured_wall_column_stepper_test.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the textured wall column stepper. A column model
// inside the bench mirrors the block's column state and predicts one result
// for every accepted input transfer. Output transfers are compared field by
// field, in order, with those predictions.
module textured_wall_column_stepper_test;
	import twcs_pkg::*;

	// One input item, with the same fields as the input ports.
	typedef struct {
		logic                    operation;
		logic [DIST_W-1:0]       perp_distance;
		logic                    hit_side;
		logic signed [DIR_W-1:0] ray_dir_x;
		logic signed [DIR_W-1:0] ray_dir_y;
		logic [DIST_W-1:0]       player_x;
		logic [DIST_W-1:0]       player_y;
		logic                    step_x_negative;
		logic                    step_y_negative;
	} hit_item_t;

	// The column model holds its own copy of the screen height and of the
	// column state, and keeps the predicted results in transfer order.
	class column_model;
		logic [ROW_W-1:0]      height;
		logic [ROW_W-1:0]      cur_row;
		logic [ROW_W-1:0]      end_row;
		logic [ROW_W-1:0]      col_start;
		logic [POS_W-1:0]      tex_pos;
		logic [STEP_W-1:0]     tex_step;
		logic [TEX_W_BITS-1:0] col_texel;
		face_t                 col_face;
		logic                  col_shade;
		result_t               predicted_outputs[$];
		int                    failures;

		function new();
			height    = SCREEN_HEIGHT_RESET;
			cur_row   = '0;
			end_row   = '0;
			col_start = '0;
			tex_pos   = '0;
			tex_step  = '0;
			col_texel = '0;
			col_face  = FACE_NORTH;
			col_shade = 1'b0;
			failures  = 0;
		endfunction

		function void set_height(logic [ROW_W-1:0] value);
			height = value;
		endfunction

		function int rows_left();
			return (cur_row < end_row) ? int'(end_row - cur_row) : 0;
		endfunction

		function int pending();
			return predicted_outputs.size();
		endfunction

		function result_t column_result(logic [ROW_W-1:0] row, logic valid, logic is_last);
			result_t r;
			r.draw_start  = col_start;
			r.draw_end    = end_row;
			r.screen_row  = row;
			r.texel_x     = col_texel;
			r.texel_y     = tex_pos[POS_W-1:FRAC_BITS];
			r.wall_face   = col_face;
			r.shade       = col_shade;
			r.pixel_valid = valid;
			r.last        = is_last;
			return r;
		endfunction

		// Works out the wall slice of a new column from one ray hit.
		function void start_column(hit_item_t it);
			logic [DIST_W-1:0]       hit_dist;
			logic signed [DIR_W-1:0] dir;
			logic signed [63:0]      prod;
			logic [63:0]             line, half_l, half_h, first, stop, offset;
			logic [63:0]             total, step, pos_full;
			logic [TEX_W_BITS-1:0]   tex;

			hit_dist = (it.perp_distance == '0) ? DIST_W'(1) : it.perp_distance;
			line   = (64'(height) << FRAC_BITS) / 64'(hit_dist);
			half_l = line >> 1;
			half_h = 64'(height) >> 1;
			first  = (half_l >= half_h) ? 64'd0 : half_h - half_l;
			stop   = half_l + half_h;
			if (stop >= 64'(height))
				stop = 64'(height);

			// Only the fraction of the hit point along the wall matters.
			dir   = it.hit_side ? it.ray_dir_x : it.ray_dir_y;
			prod  = $signed(64'(hit_dist)) * 64'(dir);
			total = (64'(it.hit_side ? it.player_x : it.player_y) << FRAC_BITS) + 64'(prod);
			tex   = total[2*FRAC_BITS-1 -: TEX_W_BITS];
			if ((!it.hit_side && it.ray_dir_x > 0) || (it.hit_side && it.ray_dir_y < 0))
				tex = TEX_W_BITS'((1 << TEX_W_BITS) - 1) - tex;

			step = (line == 0) ? 64'(STEP_LIMIT) : (64'd1 << POS_W) / line;
			if (step > 64'(STEP_LIMIT))
				step = 64'(STEP_LIMIT);
			offset   = (half_l > half_h) ? half_l - half_h : 64'd0;
			pos_full = 64'(offset[POS_W-1:0]) * step;

			if (it.hit_side)
				col_face = it.step_y_negative ? FACE_SOUTH : FACE_NORTH;
			else
				col_face = it.step_x_negative ? FACE_EAST : FACE_WEST;
			col_shade = it.hit_side;
			col_texel = tex;
			col_start = first[ROW_W-1:0];
			cur_row   = first[ROW_W-1:0];
			end_row   = stop[ROW_W-1:0];
			tex_step  = step[STEP_W-1:0];
			tex_pos   = pos_full[POS_W-1:0];
		endfunction

		// Called for every accepted input transfer.
		function void take_item(hit_item_t it);
			result_t r;
			if (it.operation == OP_SETUP) begin
				start_column(it);
				r = column_result(col_start, 1'b0, 1'b0);
			end else if (cur_row >= end_row) begin
				r = column_result(cur_row, 1'b0, 1'b0);
			end else begin
				r = column_result(cur_row, 1'b1, ROW_W'(cur_row + 1) == end_row);
				tex_pos = tex_pos + tex_step[POS_W-1:0];
				cur_row = cur_row + 1'b1;
			end
			predicted_outputs.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				failures++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		// Called for every accepted output transfer.
		function void check_output(result_t got);
			result_t want;
			if (predicted_outputs.size() == 0) begin
				failures++;
				$display("%0t: result with no prediction waiting, expected none, got row %0d",
					$time, got.screen_row);
				return;
			end
			want = predicted_outputs.pop_front();
			compare_field("draw_start", want.draw_start, got.draw_start);
			compare_field("draw_end", want.draw_end, got.draw_end);
			compare_field("screen_row", want.screen_row, got.screen_row);
			compare_field("texel_x", want.texel_x, got.texel_x);
			compare_field("texel_y", want.texel_y, got.texel_y);
			compare_field("wall_face", want.wall_face, got.wall_face);
			compare_field("shade", want.shade, got.shade);
			compare_field("pixel_valid", want.pixel_valid, got.pixel_valid);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	// Even the slowest phases stay far below this limit.
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int SETTLE_CYCLES = 70;
	localparam int HOLD_CYCLES = 300;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_write_en = 1'b0;
	logic [ROW_W-1:0]        cfg_write_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    operation = OP_PIXEL;
	logic [DIST_W-1:0]       perp_distance = '0;
	logic                    hit_side = 1'b0;
	logic signed [DIR_W-1:0] ray_dir_x = '0;
	logic signed [DIR_W-1:0] ray_dir_y = '0;
	logic [DIST_W-1:0]       player_x = '0;
	logic [DIST_W-1:0]       player_y = '0;
	logic                    step_x_negative = 1'b0;
	logic                    step_y_negative = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [ROW_W-1:0]        draw_start;
	logic [ROW_W-1:0]        draw_end;
	logic [ROW_W-1:0]        screen_row;
	logic [TEX_W_BITS-1:0]   texel_x;
	logic [TEX_H_BITS-1:0]   texel_y;
	logic [1:0]              wall_face;
	logic                    shade;
	logic                    pixel_valid;
	logic                    last;

	column_model columns;

	// Idle rates of both sides, in percent of cycles. The stimulus process sets
	// them per phase; the sender and the receiver process read them.
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;

	// Long receiver hold-offs are requested by the stimulus process and
	// counted out by the receiver process.
	int unsigned hold_requests = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;

	textured_wall_column_stepper dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.perp_distance  (perp_distance),
		.hit_side       (hit_side),
		.ray_dir_x      (ray_dir_x),
		.ray_dir_y      (ray_dir_y),
		.player_x       (player_x),
		.player_y       (player_y),
		.step_x_negative(step_x_negative),
		.step_y_negative(step_y_negative),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.draw_start     (draw_start),
		.draw_end       (draw_end),
		.screen_row     (screen_row),
		.texel_x        (texel_x),
		.texel_y        (texel_y),
		.wall_face      (wall_face),
		.shade          (shade),
		.pixel_valid    (pixel_valid),
		.last           (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Timeout guard. Hitting it means the block stopped moving transfers.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver. It stalls at the phase rate, except while a requested long
	// hold-off is running, during which the stall stays high throughout.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Output monitor. Values are sampled at the edge, before this edge's updates
	// land, so they are the ones the transfer carried.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.draw_start  = draw_start;
			got.draw_end    = draw_end;
			got.screen_row  = screen_row;
			got.texel_x     = texel_x;
			got.texel_y     = texel_y;
			got.wall_face   = face_t'(wall_face);
			got.shade       = shade;
			got.pixel_valid = pixel_valid;
			got.last        = last;
			columns.check_output(got);
		end
	end

	// Offers one item and returns at the edge where it transfers. Valid stays
	// high on return so back-to-back items go out without a bubble; it is only
	// dropped when the sender decides to idle or the stimulus drains.
	task automatic offer_item(input hit_item_t it);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		operation       <= it.operation;
		perp_distance   <= it.perp_distance;
		hit_side        <= it.hit_side;
		ray_dir_x       <= it.ray_dir_x;
		ray_dir_y       <= it.ray_dir_y;
		player_x        <= it.player_x;
		player_y        <= it.player_y;
		step_x_negative <= it.step_x_negative;
		step_y_negative <= it.step_y_negative;
		do
			@(posedge clk);
		while (in_stall);
		columns.take_item(it);
	endtask

	// Stops offering and waits until every predicted result has come out, then
	// waits on so the block is surely idle before a register write.
	task automatic drain();
		in_valid <= 1'b0;
		while (columns.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_height(input logic [ROW_W-1:0] value);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		columns.set_height(value);
	endtask

	// Pixel items carry random noise in the fields the block ignores for them.
	function automatic hit_item_t pixel_item();
		hit_item_t it;
		it.operation       = OP_PIXEL;
		it.perp_distance   = $urandom();
		it.hit_side        = $urandom_range(1);
		it.ray_dir_x       = DIR_W'($urandom());
		it.ray_dir_y       = DIR_W'($urandom());
		it.player_x        = $urandom();
		it.player_y        = $urandom();
		it.step_x_negative = $urandom_range(1);
		it.step_y_negative = $urandom_range(1);
		return it;
	endfunction

	function automatic hit_item_t setup_item(input logic [DIST_W-1:0] hit_dist, input logic side,
			input logic signed [DIR_W-1:0] dx, input logic signed [DIR_W-1:0] dy,
			input logic [DIST_W-1:0] px, input logic [DIST_W-1:0] py,
			input logic sx, input logic sy);
		hit_item_t it;
		it.operation       = OP_SETUP;
		it.perp_distance   = hit_dist;
		it.hit_side        = side;
		it.ray_dir_x       = dx;
		it.ray_dir_y       = dy;
		it.player_x        = px;
		it.player_y        = py;
		it.step_x_negative = sx;
		it.step_y_negative = sy;
		return it;
	endfunction

	// Random hit. Most distances aim at a short wall line for the current screen
	// height, so that columns are walked to their last row; the rest are zero,
	// tiny (huge, clamped lines with a texture offset) or fully random.
	function automatic hit_item_t random_setup();
		logic [DIST_W-1:0]       hit_dist;
		logic signed [DIR_W-1:0] dx, dy;
		int unsigned             h, line_max, target;
		h = columns.height;
		case ($urandom_range(9))
			0: hit_dist = '0;
			1: hit_dist = $urandom_range(1, 255);
			2, 3: hit_dist = $urandom();
			default: begin
				line_max = (2 * h + 4 < 60) ? 2 * h + 4 : 60;
				target = $urandom_range(1, line_max);
				hit_dist = DIST_W'(((64'(h) << FRAC_BITS) / target) + $urandom_range(0, 255));
			end
		endcase
		dx = ($urandom_range(7) == 0) ? '0 : DIR_W'($urandom());
		dy = ($urandom_range(7) == 0) ? '0 : DIR_W'($urandom());
		return setup_item(hit_dist, $urandom_range(1), dx, dy, $urandom(), $urandom(),
			$urandom_range(1), $urandom_range(1));
	endfunction

	// Mostly well-formed columns: a setup followed by exactly its rows, or a
	// few more to run past the end. Mixed in are stray pixels before a setup,
	// setups that cut a column short and back-to-back setups.
	task automatic run_columns(input int budget);
		int sent, rows, count;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(9) == 0) begin
				offer_item(pixel_item());
				sent++;
			end
			offer_item(random_setup());
			sent++;
			rows = columns.rows_left();
			case ($urandom_range(9))
				0: count = 0;
				1: count = $urandom_range(0, rows);
				default: count = rows + $urandom_range(0, 2);
			endcase
			if (count > 48)
				count = $urandom_range(16, 48);
			repeat (count) begin
				offer_item(pixel_item());
				sent++;
			end
		end
	endtask

	initial begin
		int unsigned heights[8];
		int unsigned phase;

		columns = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset screen height of 480.
		// A pixel before any setup finds no row left.
		offer_item(pixel_item());
		// Distance 1.0 gives a full-screen line; X side looking along +x flips.
		offer_item(setup_item(32'h0001_0000, 1'b0, 19'sd1, '0, '0, '1, 1'b0, 1'b0));
		repeat (2) offer_item(pixel_item());
		// Zero distance counts as one least step; east face, extreme directions.
		offer_item(setup_item('0, 1'b0, -19'sd262144, 19'sd262143, '1, '0, 1'b1, 1'b0));
		offer_item(pixel_item());
		// Largest distance: zero line height, saturated step, empty column.
		offer_item(setup_item('1, 1'b1, '0, -19'sd1, '1, '1, 1'b1, 1'b1));
		offer_item(pixel_item());
		// Three-row line: two pixels, the second marked last, then one past the end.
		offer_item(setup_item(32'd10485760, 1'b1, 19'sd262143, 19'sd5, 32'h8000_0000,
			32'h0000_FFFF, 1'b0, 1'b0));
		repeat (3) offer_item(pixel_item());
		// Line taller than the screen: clamped window and a nonzero texture start.
		offer_item(setup_item(32'h0000_8000, 1'b0, '0, -19'sd262144, 32'h1234_5678,
			32'h0000_7FFF, 1'b0, 1'b1));
		repeat (2) offer_item(pixel_item());
		drain();

		// Random phases: two screen heights per idling pattern, the extremes
		// among them. The first phase also runs the long receiver hold-off.
		heights[0] = 4095;
		heights[1] = 1;
		heights[2] = 0;
		heights[3] = 480;
		heights[4] = 2;
		heights[5] = $urandom_range(3, 600);
		heights[6] = 4095;
		heights[7] = $urandom_range(16, 200);
		for (int seg = 0; seg < 8; seg++) begin
			phase = seg / 2;
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 77;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 77;
				end
				default: begin
					send_idle_pct = 36;
					stall_pct = 36;
				end
			endcase
			write_height(ROW_W'(heights[seg]));
			if (seg == 0)
				hold_requests = hold_requests + 1;
			run_columns(92);
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (columns.failures == 0 && columns.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
